### src/dac_pkg.sv
`default_nettype none

package dac_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int MAX_PIN_DIGITS = 8;

  localparam int SLOT_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_IDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int PIN_CNT_W  = $clog2(MAX_PIN_DIGITS + 1);
  localparam int PIN_BUF_W  = 4 * MAX_PIN_DIGITS;

  localparam int OP_W      = 3;
  localparam int UID_W     = 56;
  localparam int SHORT_W   = 32;
  localparam int KEY_W     = UID_W + 1;
  localparam int DIGIT_W   = 4;
  localparam int STATUS_W  = 4;
  localparam int OUT_SLOT_W = 4;
  localparam int TIME_W    = 32;
  localparam int PIN_W     = 16;
  localparam int COOL_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [PIN_CNT_W-1:0] PIN_LEN = PIN_CNT_W'(4);

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_CARD   = 3'd1;
  localparam logic [OP_W-1:0] OP_DIGIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENTER  = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PIN_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd3;

  localparam logic [PIN_W-1:0]  PIN_A_RST    = 16'h1234;
  localparam logic [PIN_W-1:0]  PIN_B_RST    = 16'h5678;
  localparam logic [TIME_W-1:0] UNLOCK_RST   = 32'd5000;
  localparam logic [COOL_W-1:0] COOLDOWN_RST = 16'd2500;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE        = 4'd0,
    ST_CARD_OK     = 4'd1,
    ST_CARD_DENIED = 4'd2,
    ST_COOLDOWN    = 4'd3,
    ST_PIN_OK      = 4'd4,
    ST_PIN_DENIED  = 4'd5,
    ST_ADDED       = 4'd6,
    ST_EXISTS      = 4'd7,
    ST_FULL        = 4'd8,
    ST_REMOVED     = 4'd9,
    ST_NOT_FOUND   = 4'd10,
    ST_RELOCKED    = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_run;
    logic commit;
  } dac_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic out_free;
  } dac_sts_t;

endpackage

`default_nettype wire

### src/dac_ctrl.sv
`default_nettype none

module dac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output dac_pkg::dac_cmd_t      cmd,
  input  wire dac_pkg::dac_sts_t sts
);
  import dac_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.needs_scan || sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE);
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.scan_run = (state_r == S_SCAN);
    cmd.commit   = (state_r == S_DONE) && sts.out_free;
  end

endmodule

`default_nettype wire

### src/dac_datapath.sv
`default_nettype none

module dac_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [dac_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [dac_pkg::UID_W-1:0]       in_card_uid,
  input  wire logic                            in_uid_is_long,
  input  wire logic [dac_pkg::DIGIT_W-1:0]     in_digit,
  input  wire logic                            cfg_we,
  input  wire logic [dac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dac_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire dac_pkg::dac_cmd_t               cmd,
  output dac_pkg::dac_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dac_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_door_unlocked,
  output logic                                 out_buzzer,
  output logic [dac_pkg::OUT_SLOT_W-1:0]       out_slot,
  output logic                                 out_slot_valid
);
  import dac_pkg::*;

  logic [PIN_W-1:0]  pin_a_r;
  logic [PIN_W-1:0]  pin_b_r;
  logic [TIME_W-1:0] unlock_ticks_r;
  logic [COOL_W-1:0] cooldown_r;

  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [DIGIT_W-1:0] digit_r;

  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]    unlock_stamp_r, unlock_stamp_nxt;
  logic [TIME_W-1:0]    last_card_r, last_card_nxt;
  logic                 unlocked_r, unlocked_nxt;
  logic [PIN_BUF_W-1:0] pin_buf_r, pin_buf_nxt;
  logic [PIN_CNT_W-1:0] pin_cnt_r, pin_cnt_nxt;
  logic                 pin_ovf_r, pin_ovf_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;

  logic [KEY_W-1:0] uid_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  logic [SCAN_IDX_W-1:0] scan_idx_r;
  logic [SLOT_W-1:0]     cmp_idx_r;
  logic                  cmp_vld_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     match_r;
  logic                  issue;
  logic [SLOT_W-1:0]     rd_addr;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_door_r;
  logic              out_buzzer_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic              out_slot_valid_r;

  logic [TIME_W-1:0] now_inc;
  logic [TIME_W-1:0] since_unlock;
  logic [TIME_W-1:0] since_card;
  logic              in_cooldown;
  logic              pin_match;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              tbl_wr;
  status_t           res_status;
  logic              res_buzzer;
  logic [SLOT_W-1:0] res_slot;
  logic              res_slot_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_a_r        <= PIN_A_RST;
      pin_b_r        <= PIN_B_RST;
      unlock_ticks_r <= UNLOCK_RST;
      cooldown_r     <= COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIN_A:    pin_a_r        <= cfg_data[PIN_W-1:0];
        CFG_PIN_B:    pin_b_r        <= cfg_data[PIN_W-1:0];
        CFG_UNLOCK:   unlock_ticks_r <= cfg_data[TIME_W-1:0];
        CFG_COOLDOWN: cooldown_r     <= cfg_data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      digit_r <= in_digit;
      key_r   <= in_uid_is_long ? {1'b1, in_card_uid} : KEY_W'(in_card_uid[SHORT_W-1:0]);
    end
  end

  assign issue   = cmd.scan_run && (scan_idx_r != SCAN_IDX_W'(TABLE_DEPTH));
  assign rd_addr = scan_idx_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      uid_mem[free_idx] <= key_r;
    end
    if (issue) begin
      rd_data_r <= uid_mem[rd_addr];
      cmp_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      match_r    <= '0;
    end else if (cmd.capture) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_vld_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + SCAN_IDX_W'(1);
      end
      if (cmp_vld_r && valid_r[cmp_idx_r] && (rd_data_r == key_r) && !found_r) begin
        found_r <= 1'b1;
        match_r <= cmp_idx_r;
      end
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    now_inc      = now_r + TIME_W'(1);
    since_unlock = now_inc - unlock_stamp_r;
    since_card   = now_r - last_card_r;
    in_cooldown  = since_card < TIME_W'(cooldown_r);
    pin_match    = !pin_ovf_r && (pin_cnt_r == PIN_LEN) &&
                   ((pin_buf_r == PIN_BUF_W'(pin_a_r)) || (pin_buf_r == PIN_BUF_W'(pin_b_r)));

    now_nxt          = now_r;
    unlock_stamp_nxt = unlock_stamp_r;
    last_card_nxt    = last_card_r;
    unlocked_nxt     = unlocked_r;
    pin_buf_nxt      = pin_buf_r;
    pin_cnt_nxt      = pin_cnt_r;
    pin_ovf_nxt      = pin_ovf_r;
    valid_nxt        = valid_r;
    tbl_wr           = 1'b0;
    res_status       = ST_NONE;
    res_buzzer       = 1'b0;
    res_slot         = '0;
    res_slot_valid   = 1'b0;

    unique case (op_r)
      OP_TICK: begin
        now_nxt = now_inc;
        if (unlocked_r && (since_unlock > unlock_ticks_r)) begin
          unlocked_nxt = 1'b0;
          res_status   = ST_RELOCKED;
        end
      end
      OP_CARD: begin
        if (in_cooldown) begin
          res_status = ST_COOLDOWN;
        end else begin
          last_card_nxt = now_r;
          if (found_r) begin
            unlocked_nxt     = 1'b1;
            unlock_stamp_nxt = now_r;
            res_status       = ST_CARD_OK;
            res_slot         = match_r;
            res_slot_valid   = 1'b1;
          end else begin
            res_status = ST_CARD_DENIED;
            res_buzzer = 1'b1;
          end
        end
      end
      OP_DIGIT: begin
        if (digit_r <= DIGIT_MAX) begin
          if (pin_cnt_r < PIN_CNT_W'(MAX_PIN_DIGITS)) begin
            pin_buf_nxt = {pin_buf_r[PIN_BUF_W-DIGIT_W-1:0], digit_r};
            pin_cnt_nxt = pin_cnt_r + PIN_CNT_W'(1);
          end else begin
            pin_ovf_nxt = 1'b1;
          end
        end
      end
      OP_ENTER: begin
        if ((pin_cnt_r != '0) || pin_ovf_r) begin
          if (pin_match) begin
            unlocked_nxt     = 1'b1;
            unlock_stamp_nxt = now_r;
            res_status       = ST_PIN_OK;
          end else begin
            res_status = ST_PIN_DENIED;
            res_buzzer = 1'b1;
          end
          pin_buf_nxt = '0;
          pin_cnt_nxt = '0;
          pin_ovf_nxt = 1'b0;
        end
      end
      OP_ADD: begin
        if (found_r) begin
          res_status     = ST_EXISTS;
          res_slot       = match_r;
          res_slot_valid = 1'b1;
        end else if (free_any) begin
          tbl_wr              = cmd.commit;
          valid_nxt[free_idx] = 1'b1;
          res_status          = ST_ADDED;
          res_slot            = free_idx;
          res_slot_valid      = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          valid_nxt[match_r] = 1'b0;
          res_status         = ST_REMOVED;
          res_slot           = match_r;
          res_slot_valid     = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      unlock_stamp_r <= '0;
      last_card_r    <= '0;
      unlocked_r     <= 1'b0;
      pin_buf_r      <= '0;
      pin_cnt_r      <= '0;
      pin_ovf_r      <= 1'b0;
      valid_r        <= '0;
    end else if (cmd.commit) begin
      now_r          <= now_nxt;
      unlock_stamp_r <= unlock_stamp_nxt;
      last_card_r    <= last_card_nxt;
      unlocked_r     <= unlocked_nxt;
      pin_buf_r      <= pin_buf_nxt;
      pin_cnt_r      <= pin_cnt_nxt;
      pin_ovf_r      <= pin_ovf_nxt;
      valid_r        <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r     <= res_status;
      out_door_r       <= unlocked_nxt;
      out_buzzer_r     <= res_buzzer;
      out_slot_r       <= OUT_SLOT_W'(res_slot);
      out_slot_valid_r <= res_slot_valid;
    end
  end

  always_comb begin
    sts.needs_scan = (op_r == OP_CARD) || (op_r == OP_ADD) || (op_r == OP_REMOVE);
    sts.scan_done  = (scan_idx_r == SCAN_IDX_W'(TABLE_DEPTH)) && !cmp_vld_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_door_unlocked = out_door_r;
  assign out_buzzer        = out_buzzer_r;
  assign out_slot          = out_slot_r;
  assign out_slot_valid    = out_slot_valid_r;

  a_pin_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pin_cnt_r <= PIN_CNT_W'(MAX_PIN_DIGITS))
    else $error("pin digit count beyond limit");

  a_relock: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (res_status == ST_RELOCKED)) |=> !unlocked_r)
    else $error("door still unlocked after relock");

  a_buzzer_denied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_buzzer_r) |->
      ((out_status_r == ST_CARD_DENIED) || (out_status_r == ST_PIN_DENIED)))
    else $error("buzzer without denial");

  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (!found_r && (scan_idx_r == '0)))
    else $error("scan not cleared on capture");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (res_status == ST_ADDED)) |=> valid_r[$past(free_idx)])
    else $error("added slot not marked valid");

endmodule

`default_nettype wire

### src/door_access_controller.sv
// Door access controller.
// Input channel (in_valid / in_stall) carries one item: a millisecond tick, a
// card read, a keypad digit, a PIN enter, or an add / remove identifier command.
// Every accepted item yields exactly one result on the output channel
// (out_valid / out_stall): status code, lock state after the item, buzzer
// pulse and the table slot concerned.
// Card, add and remove items scan the 16-entry identifier table one entry a
// cycle through a single registered read port before the result is loaded;
// other items skip the scan. One item is in flight at a time; the next item
// is accepted the cycle after the result is registered.
// The result sits in an output register; while out_stall holds it, a further
// item is still accepted and worked on, and waits for the register to free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle, which it does not enforce.
// Synchronous reset (rst_n low) locks the door, clears timers, the PIN buffer
// and all table valid bits, and loads the configuration defaults.
`default_nettype none

module door_access_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dac_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [dac_pkg::UID_W-1:0]       in_card_uid,
  input  wire logic                            in_uid_is_long,
  input  wire logic [dac_pkg::DIGIT_W-1:0]     in_digit,
  input  wire logic                            cfg_we,
  input  wire logic [dac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dac_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dac_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_door_unlocked,
  output logic                                 out_buzzer,
  output logic [dac_pkg::OUT_SLOT_W-1:0]       out_slot,
  output logic                                 out_slot_valid
);
  import dac_pkg::*;

  dac_cmd_t cmd;
  dac_sts_t sts;

  dac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  dac_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_card_uid       (in_card_uid),
    .in_uid_is_long    (in_uid_is_long),
    .in_digit          (in_digit),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_door_unlocked (out_door_unlocked),
    .out_buzzer        (out_buzzer),
    .out_slot          (out_slot),
    .out_slot_valid    (out_slot_valid)
  );

endmodule

`default_nettype wire

### tb/sv/tb_door_access_controller.sv
`timescale 1ns / 1ps

module tb_door_access_controller;
  import dac_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int POOL_SIZE = 24;
  localparam int CLK_HALF = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 4_000_000;

  typedef struct {
    status_t                 status;
    logic                    door;
    logic                    buzz;
    logic [OUT_SLOT_W-1:0]   slot;
    logic                    slot_ok;
  } access_result_t;

  class access_scoreboard;
    logic [PIN_W-1:0]     pin_a;
    logic [PIN_W-1:0]     pin_b;
    logic [TIME_W-1:0]    unlock_ticks;
    logic [COOL_W-1:0]    cooldown;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    opened_at;
    logic [TIME_W-1:0]    last_card_at;
    logic                 unlocked;
    logic [PIN_BUF_W-1:0] pin_buf;
    int                   pin_cnt;
    logic                 pin_ovf;
    logic [KEY_W-1:0]     keys[TABLE_DEPTH];
    logic                 key_ok[TABLE_DEPTH];
    access_result_t       outcomes[$];
    int                   errors;
    int                   checked;
    int                   seen[16];

    function new();
      pin_a = PIN_A_RST;
      pin_b = PIN_B_RST;
      unlock_ticks = UNLOCK_RST;
      cooldown = COOLDOWN_RST;
      now = '0;
      opened_at = '0;
      last_card_at = '0;
      unlocked = 1'b0;
      pin_buf = '0;
      pin_cnt = 0;
      pin_ovf = 1'b0;
      foreach (key_ok[i]) begin
        key_ok[i] = 1'b0;
        keys[i] = '0;
      end
      foreach (seen[i]) seen[i] = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PIN_A:    pin_a = val[PIN_W-1:0];
        CFG_PIN_B:    pin_b = val[PIN_W-1:0];
        CFG_UNLOCK:   unlock_ticks = val[TIME_W-1:0];
        CFG_COOLDOWN: cooldown = val[COOL_W-1:0];
        default: ;
      endcase
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (key_ok[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void open_door();
      unlocked = 1'b1;
      opened_at = now;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [UID_W-1:0] uid, logic lng,
                            logic [DIGIT_W-1:0] dig);
      logic [KEY_W-1:0] k;
      access_result_t   r;
      int               s;
      int               i;
      k = lng ? {1'b1, uid} : {{(KEY_W-SHORT_W){1'b0}}, uid[SHORT_W-1:0]};
      r.status = ST_NONE;
      r.buzz = 1'b0;
      s = -1;
      case (op)
        OP_TICK: begin
          now = now + 1;
          if (unlocked && (now - opened_at) > unlock_ticks) begin
            unlocked = 1'b0;
            r.status = ST_RELOCKED;
          end
        end
        OP_CARD: begin
          if ((now - last_card_at) < cooldown) begin
            r.status = ST_COOLDOWN;
          end else begin
            last_card_at = now;
            s = find_key(k);
            if (s >= 0) begin
              open_door();
              r.status = ST_CARD_OK;
            end else begin
              r.status = ST_CARD_DENIED;
              r.buzz = 1'b1;
            end
          end
        end
        OP_DIGIT: begin
          if (dig <= DIGIT_MAX) begin
            if (pin_cnt < MAX_PIN_DIGITS) begin
              pin_buf = {pin_buf[PIN_BUF_W-5:0], dig};
              pin_cnt++;
            end else begin
              pin_ovf = 1'b1;
            end
          end
        end
        OP_ENTER: begin
          if (pin_cnt != 0 || pin_ovf) begin
            if (!pin_ovf && pin_cnt == 4 && (pin_buf == pin_a || pin_buf == pin_b)) begin
              open_door();
              r.status = ST_PIN_OK;
            end else begin
              r.status = ST_PIN_DENIED;
              r.buzz = 1'b1;
            end
            pin_buf = '0;
            pin_cnt = 0;
            pin_ovf = 1'b0;
          end
        end
        OP_ADD: begin
          s = find_key(k);
          if (s >= 0) begin
            r.status = ST_EXISTS;
          end else begin
            for (i = 0; i < TABLE_DEPTH && s < 0; i++) begin
              if (!key_ok[i]) begin
                keys[i] = k;
                key_ok[i] = 1'b1;
                s = i;
              end
            end
            r.status = (s >= 0) ? ST_ADDED : ST_FULL;
          end
        end
        OP_REMOVE: begin
          s = find_key(k);
          if (s >= 0) begin
            key_ok[s] = 1'b0;
            r.status = ST_REMOVED;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      r.door = unlocked;
      r.slot = (s >= 0) ? OUT_SLOT_W'(s) : '0;
      r.slot_ok = (s >= 0);
      outcomes.insert(outcomes.size(), r);
    endfunction

    function void compare_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic door, logic buzz,
                               logic [OUT_SLOT_W-1:0] slot, logic slot_ok);
      access_result_t e;
      checked++;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got status %0d",
                 $time, st);
        return;
      end
      e = outcomes.pop_front();
      seen[int'(e.status)]++;
      compare_field("status", e.status, st);
      compare_field("door_unlocked", e.door, door);
      compare_field("buzzer", e.buzz, buzz);
      compare_field("slot", e.slot, slot);
      compare_field("slot_valid", e.slot_ok, slot_ok);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_opcode = OP_TICK;
  logic [UID_W-1:0]        in_card_uid = '0;
  logic                    in_uid_is_long = 1'b0;
  logic [DIGIT_W-1:0]      in_digit = '0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_PIN_A;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_door_unlocked;
  logic                    out_buzzer;
  logic [OUT_SLOT_W-1:0]   out_slot;
  logic                    out_slot_valid;

  door_access_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_card_uid      (in_card_uid),
    .in_uid_is_long   (in_uid_is_long),
    .in_digit         (in_digit),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_door_unlocked(out_door_unlocked),
    .out_buzzer       (out_buzzer),
    .out_slot         (out_slot),
    .out_slot_valid   (out_slot_valid)
  );

  access_scoreboard     sb;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  bit                   fill_bias = 1'b0;
  int                   driven = 0;
  int                   settings = 0;
  logic [UID_W-1:0]     pool_uid[POOL_SIZE];
  logic                 pool_long[POOL_SIZE];

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_door_unlocked, out_buzzer, out_slot, out_slot_valid);
      if (in_valid && !in_stall)
        sb.note_item(in_opcode, in_card_uid, in_uid_is_long, in_digit);
    end
  end

  function automatic logic [UID_W-1:0] rand_uid();
    return UID_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PIN_W-1:0] rand_bcd();
    logic [PIN_W-1:0] v;
    for (int i = 0; i < 4; i++) v[4*i +: 4] = DIGIT_W'($urandom_range(9));
    return v;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid,
                           input logic lng, input logic [DIGIT_W-1:0] dig);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_card_uid <= uid;
    in_uid_is_long <= lng;
    in_digit <= dig;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op <= OP_REMOVE && !(op == OP_DIGIT && dig > DIGIT_MAX)) driven++;
  endtask

  task automatic send_simple(input logic [OP_W-1:0] op);
    send_item(op, rand_uid(), 1'($urandom), DIGIT_W'($urandom));
  endtask

  task automatic send_digit(input logic [DIGIT_W-1:0] d);
    send_item(OP_DIGIT, rand_uid(), 1'($urandom), d);
  endtask

  task automatic send_key(input logic [OP_W-1:0] op, input int idx);
    logic [UID_W-1:0] uid;
    uid = pool_uid[idx];
    if (!pool_long[idx]) uid[UID_W-1:SHORT_W] = (UID_W-SHORT_W)'($urandom);
    send_item(op, uid, pool_long[idx], DIGIT_W'($urandom));
  endtask

  task automatic send_pin(input logic [PIN_W-1:0] code, input bit stray);
    for (int i = 3; i >= 0; i--) begin
      if (stray && i == 2) send_digit(DIGIT_W'($urandom_range(10, 15)));
      send_digit(code[4*i +: 4]);
    end
    send_simple(OP_ENTER);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_phase(input logic [PIN_W-1:0] pa, input logic [PIN_W-1:0] pb,
                           input logic [TIME_W-1:0] unl, input logic [COOL_W-1:0] cool,
                           input int idle, input int stall, input bit fill);
    write_reg(CFG_PIN_A, CFG_DATA_W'(pa));
    write_reg(CFG_PIN_B, CFG_DATA_W'(pb));
    write_reg(CFG_UNLOCK, CFG_DATA_W'(unl));
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(cool));
    settings++;
    send_idle_pct = idle;
    stall_pct = stall;
    fill_bias = fill;
  endtask

  task automatic random_traffic();
    int pick;
    int n;
    int k;
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) send_simple(OP_TICK);
    end else if (pick < 52) begin
      if ($urandom_range(5) == 0) send_simple(OP_CARD);
      else send_key(OP_CARD, $urandom_range(POOL_SIZE - 1));
    end else if (pick < 67) begin
      k = $urandom_range(9);
      if (k < 6) begin
        send_pin($urandom_range(1) ? sb.pin_a : sb.pin_b, 1'b0);
      end else if (k == 6) begin
        send_pin(rand_bcd(), 1'b0);
      end else if (k == 9) begin
        send_pin($urandom_range(1) ? sb.pin_a : sb.pin_b, 1'b1);
      end else begin
        n = (k == 7) ? ($urandom_range(1) ? 3 : 5) : $urandom_range(9, 12);
        repeat (n) send_digit(DIGIT_W'($urandom_range(9)));
        send_simple(OP_ENTER);
      end
    end else if (pick < (fill_bias ? 87 : 79)) begin
      send_key(OP_ADD, $urandom_range(POOL_SIZE - 1));
    end else if (pick < 93) begin
      send_key(OP_REMOVE, $urandom_range(POOL_SIZE - 1));
    end else if (pick < 97) begin
      if ($urandom_range(1)) send_simple(OP_ENTER);
      else send_digit(DIGIT_W'($urandom));
    end else begin
      send_simple($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B);
    end
  endtask

  task automatic run_phase();
    int start;
    start = driven;
    while (driven - start < ITEMS_PER_PHASE) random_traffic();
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_uid[i] = rand_uid();
      pool_long[i] = i[0];
    end
    pool_uid[1] = pool_uid[0];
    pool_uid[2] = '1;
    pool_uid[3] = '1;
    pool_uid[4] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_key(OP_CARD, 3);
    send_simple(OP_ENTER);
    send_pin(PIN_A_RST, 1'b0);
    send_digit(4'hF);
    send_item(OP_SPARE_B, '1, 1'b1, 4'hF);
    write_reg(CFG_COOLDOWN, '0);
    write_reg(CFG_UNLOCK, '0);
    send_key(OP_ADD, 3);
    send_key(OP_ADD, 4);
    send_key(OP_ADD, 3);
    send_key(OP_CARD, 3);
    send_simple(OP_TICK);
    send_item(OP_CARD, '0, 1'b1, 4'h0);
    send_key(OP_REMOVE, 3);
    send_key(OP_REMOVE, 3);
    for (int i = 0; i < 9; i++) send_digit(i[0] ? 4'd9 : 4'd0);
    send_simple(OP_ENTER);

    set_phase(16'h0000, 16'h9999, 32'd0, 16'd0, 0, 0, 1'b0);
    run_phase();
    set_phase(16'h4321, 16'h12A4, 32'd3, 16'd2, 83, 0, 1'b1);
    run_phase();
    set_phase(rand_bcd(), rand_bcd(), 32'd20, 16'd5, 0, 83, 1'b1);
    run_phase();
    set_phase(rand_bcd(), 16'h5678, 32'hFFFF_FFFF, 16'd1, 37, 37, 1'b0);
    run_phase();
    set_phase(16'h9999, 16'h0000, 32'd8, 16'hFFFF, 0, 0, 1'b1);
    run_phase();
    set_phase(rand_bcd(), rand_bcd(), 32'd1, 16'd0, 37, 37, 1'b0);
    run_phase();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d items across %0d register settings, %0d results compared",
             driven, settings, sb.checked);
    $display("Cards ok/denied/cooldown %0d/%0d/%0d, PINs ok/denied %0d/%0d, %s %0d/%0d/%0d, relocks %0d",
             sb.seen[ST_CARD_OK], sb.seen[ST_CARD_DENIED], sb.seen[ST_COOLDOWN],
             sb.seen[ST_PIN_OK], sb.seen[ST_PIN_DENIED], "added/full/removed",
             sb.seen[ST_ADDED], sb.seen[ST_FULL], sb.seen[ST_REMOVED],
             sb.seen[ST_RELOCKED]);
    if (sb.errors == 0 && sb.outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
